[rtl/rdb_pkg.sv]
// ----------------------------------------------------------------------------
// rdb_pkg
// Types and constants shared by the dump stream parser: parse phases, item
// kinds, opcode bytes and the result item record.
// ----------------------------------------------------------------------------
package rdb_pkg;

    // Bytes of file header skipped before the first opcode
    localparam logic [3:0] HEADER_BYTES = 4'd9;

    // Opcode bytes
    localparam logic [7:0] OP_AUX        = 8'hFA;
    localparam logic [7:0] OP_RESIZE     = 8'hFB;
    localparam logic [7:0] OP_EXPIRY_MS  = 8'hFC;
    localparam logic [7:0] OP_EXPIRY_SEC = 8'hFD;
    localparam logic [7:0] OP_SELECT     = 8'hFE;
    localparam logic [7:0] OP_EOF        = 8'hFF;

    // Length prefix forms (top two bits)
    localparam logic [1:0] LEN_6BIT  = 2'd0;
    localparam logic [1:0] LEN_14BIT = 2'd1;
    localparam logic [1:0] LEN_32BIT = 2'd2;
    localparam logic [1:0] LEN_ENC   = 2'd3;

    // String roles
    localparam logic [1:0] ROLE_AUX_KEY = 2'd0;
    localparam logic [1:0] ROLE_KEY     = 2'd1;
    localparam logic [1:0] ROLE_VALUE   = 2'd2;
    localparam logic [1:0] ROLE_AUX_VAL = 2'd3;

    // Skip purposes while a skipped length is read
    localparam logic [3:0] SKIP_DB_ID    = 4'd0;
    localparam logic [3:0] SKIP_HASH_SZ  = 4'd1;
    localparam logic [3:0] SKIP_EXPIRE_SZ = 4'd2;

    // String item sub-kinds
    localparam logic [1:0] SUB_BYTE   = 2'd0;
    localparam logic [1:0] SUB_NUMBER = 2'd1;
    localparam logic [1:0] SUB_EMPTY  = 2'd2;

    localparam logic [9:0] MS_PER_SEC = 10'd1000;

    typedef enum logic [3:0] {
        PH_HEADER,
        PH_OPCODE,
        PH_AFTER_SELECT,
        PH_SKIPLEN_FIRST,
        PH_SKIPLEN_REST,
        PH_STR_FIRST,
        PH_STR_LEN,
        PH_STR_INT,
        PH_STR_BODY,
        PH_EXPIRY,
        PH_TYPE,
        PH_DONE
    } rdb_phase_t;

    localparam rdb_phase_t PHASE_INIT = (HEADER_BYTES > 4'd0) ? PH_HEADER : PH_OPCODE;

    typedef enum logic [3:0] {
        KIND_KEY_BYTE   = 4'd0,
        KIND_KEY_NUMBER = 4'd1,
        KIND_KEY_EMPTY  = 4'd2,
        KIND_VAL_BYTE   = 4'd3,
        KIND_VAL_NUMBER = 4'd4,
        KIND_VAL_EMPTY  = 4'd5,
        KIND_EXPIRY     = 4'd6,
        KIND_FILE_END   = 4'd7,
        KIND_TRUNCATED  = 4'd8
    } rdb_kind_t;

    typedef struct packed {
        rdb_kind_t   kind;
        logic [7:0]  payload_byte;
        logic [63:0] number;
        logic        string_done;
        logic        entry_done;
        logic        cut_short;
    } rdb_item_t;

endpackage

[rtl/rdb_dump_stream_parser.sv]
// ----------------------------------------------------------------------------
// rdb_dump_stream_parser
// Byte-wide parser for a key-value dump file. Skips header, aux fields and
// database select, emits key/value bytes, integer-encoded numbers, empty
// markers, expiry in milliseconds, file end and truncation.
// ----------------------------------------------------------------------------
//
//  channel | direction | ports                               | item
//  --------+-----------+-------------------------------------+-------------------
//  s_      | in        | s_valid s_ready                     | one file byte
//  m_      | out       | m_valid m_ready                     | zero or one result
//
//  One byte is taken every cycle while s_ready is high; a byte is held in the
//  input register, and its result is then registered in the result register.
//  All decode work for a byte sits between the input register and the result
//  register; the expiry path holds one 32x10 multiply.
//  Reset (aresetn low, synchronous) returns the parser to header skip.
//  A stalled m_ready holds the result; the input register holds one byte,
//  so s_ready drops only when both registers are full and m_ready is low.
//
module rdb_dump_stream_parser (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_last_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [3:0]  m_kind,
    output logic [7:0]  m_payload_byte,
    output logic [63:0] m_number,
    output logic        m_string_done,
    output logic        m_entry_done,
    output logic        m_cut_short
);
    import rdb_pkg::*;

    // input register
    logic       in_valid_reg;
    logic [7:0] in_data_reg;
    logic       in_last_reg;

    // parser state
    rdb_phase_t  phase_reg, phase_next;
    logic [3:0]  hdr_cnt_reg, hdr_cnt_next;
    logic [31:0] remain_reg, remain_next;
    logic [63:0] word_reg, word_next;
    logic [3:0]  idx_reg, idx_next;
    logic [1:0]  role_reg, role_next;
    logic        entry_reg, entry_next;

    // result register
    logic      out_valid_reg;
    rdb_item_t out_item_reg;

    // events raised by the decode block
    logic        str_go;
    logic [1:0]  str_sub;
    logic        str_last;
    logic        eof_go;
    logic        exp_go;
    logic        cut_go;
    logic [63:0] exp_ms;

    logic        have;
    rdb_item_t   item;

    logic        advance;
    logic [1:0]  hi;
    logic [5:0]  low;
    logic [3:0]  hdr_inc;
    logic [63:0] exp_word;
    logic [63:0] int_word;
    logic [31:0] remain_dec;
    logic [41:0] sec_ms;
    logic        op_go;
    logic        skip_go;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    assign hi         = in_data_reg[7:6];
    assign low        = in_data_reg[5:0];
    assign hdr_inc    = hdr_cnt_reg + 4'd1;
    assign remain_dec = remain_reg - 32'd1;
    assign exp_word   = word_reg | ({56'd0, in_data_reg} << {idx_reg[2:0], 3'b000});
    assign int_word   = word_reg | ({56'd0, in_data_reg} << {1'b0, idx_reg[1:0], 3'b000});
    assign sec_ms     = {10'd0, exp_word[31:0]} * {32'd0, MS_PER_SEC};

    // Next-state decode
    always_comb begin
        phase_next   = phase_reg;
        hdr_cnt_next = hdr_cnt_reg;
        remain_next  = remain_reg;
        word_next    = word_reg;
        idx_next     = idx_reg;
        role_next    = role_reg;
        entry_next   = entry_reg;
        str_go       = 1'b0;
        str_sub      = SUB_BYTE;
        str_last     = 1'b0;
        eof_go       = 1'b0;
        exp_go       = 1'b0;
        cut_go       = 1'b0;
        exp_ms       = 64'd0;
        op_go        = 1'b0;
        skip_go      = 1'b0;

        unique case (phase_reg)
            PH_HEADER: begin
                hdr_cnt_next = hdr_inc;
                if (hdr_inc >= HEADER_BYTES || hdr_inc == 4'd0) begin
                    phase_next = PH_OPCODE;
                end
            end
            PH_OPCODE: begin
                op_go = 1'b1;
            end
            PH_AFTER_SELECT: begin
                if (in_data_reg == OP_RESIZE) begin
                    idx_next   = SKIP_HASH_SZ;
                    phase_next = PH_SKIPLEN_FIRST;
                end else begin
                    phase_next = PH_OPCODE;
                    op_go      = 1'b1;
                end
            end
            PH_SKIPLEN_FIRST: begin
                if (hi == LEN_14BIT) begin
                    remain_next = 32'd1;
                    phase_next  = PH_SKIPLEN_REST;
                end else if (hi == LEN_32BIT) begin
                    remain_next = 32'd4;
                    phase_next  = PH_SKIPLEN_REST;
                end else begin
                    skip_go = 1'b1;
                end
            end
            PH_SKIPLEN_REST: begin
                remain_next = remain_dec;
                skip_go     = (remain_dec == 32'd0);
            end
            PH_STR_FIRST: begin
                if (hi == LEN_ENC) begin
                    if (low <= 6'd2) begin
                        word_next   = 64'd0;
                        idx_next    = 4'd0;
                        remain_next = 32'd1 << low[1:0];
                        phase_next  = PH_STR_INT;
                    end else begin
                        str_go   = 1'b1;
                        str_sub  = SUB_EMPTY;
                        str_last = 1'b1;
                    end
                end else if (hi == LEN_6BIT) begin
                    if (low == 6'd0) begin
                        str_go   = 1'b1;
                        str_sub  = SUB_EMPTY;
                        str_last = 1'b1;
                    end else begin
                        remain_next = {26'd0, low};
                        phase_next  = PH_STR_BODY;
                    end
                end else begin
                    word_next   = (hi == LEN_14BIT) ? {58'd0, low} : 64'd0;
                    remain_next = (hi == LEN_14BIT) ? 32'd1 : 32'd4;
                    phase_next  = PH_STR_LEN;
                end
            end
            PH_STR_LEN: begin
                word_next   = {32'd0, word_reg[23:0], in_data_reg};
                remain_next = remain_dec;
                if (remain_dec == 32'd0) begin
                    if ({word_reg[23:0], in_data_reg} == 32'd0) begin
                        str_go   = 1'b1;
                        str_sub  = SUB_EMPTY;
                        str_last = 1'b1;
                    end else begin
                        remain_next = {word_reg[23:0], in_data_reg};
                        phase_next  = PH_STR_BODY;
                    end
                end
            end
            PH_STR_INT: begin
                word_next   = int_word;
                idx_next    = idx_reg + 4'd1;
                remain_next = remain_dec;
                if (remain_dec == 32'd0) begin
                    str_go   = 1'b1;
                    str_sub  = SUB_NUMBER;
                    str_last = 1'b1;
                end
            end
            PH_STR_BODY: begin
                remain_next = remain_dec;
                str_go      = 1'b1;
                str_sub     = SUB_BYTE;
                str_last    = (remain_dec == 32'd0);
            end
            PH_EXPIRY: begin
                word_next   = exp_word;
                idx_next    = idx_reg + 4'd1;
                remain_next = remain_dec;
                if (remain_dec == 32'd0) begin
                    exp_go     = 1'b1;
                    exp_ms     = (idx_reg + 4'd1 == 4'd4) ? {22'd0, sec_ms} : exp_word;
                    phase_next = PH_TYPE;
                end
            end
            PH_TYPE: begin
                role_next  = ROLE_KEY;
                phase_next = PH_STR_FIRST;
            end
            default: begin
            end
        endcase

        if (op_go) begin
            if (entry_reg && in_data_reg != OP_AUX && in_data_reg != OP_SELECT &&
                in_data_reg != OP_EOF) begin
                if (in_data_reg == OP_EXPIRY_SEC || in_data_reg == OP_EXPIRY_MS) begin
                    word_next   = 64'd0;
                    idx_next    = 4'd0;
                    remain_next = (in_data_reg == OP_EXPIRY_SEC) ? 32'd4 : 32'd8;
                    phase_next  = PH_EXPIRY;
                end else begin
                    role_next  = ROLE_KEY;
                    phase_next = PH_STR_FIRST;
                end
            end else begin
                entry_next = 1'b0;
                if (in_data_reg == OP_AUX) begin
                    role_next  = ROLE_AUX_KEY;
                    phase_next = PH_STR_FIRST;
                end else if (in_data_reg == OP_SELECT) begin
                    entry_next = 1'b1;
                    idx_next   = SKIP_DB_ID;
                    phase_next = PH_SKIPLEN_FIRST;
                end else if (in_data_reg == OP_EOF) begin
                    eof_go     = 1'b1;
                    phase_next = PH_DONE;
                end
            end
        end

        if (skip_go) begin
            if (idx_reg == SKIP_DB_ID) begin
                phase_next = PH_AFTER_SELECT;
            end else if (idx_reg == SKIP_HASH_SZ) begin
                idx_next   = SKIP_EXPIRE_SZ;
                phase_next = PH_SKIPLEN_FIRST;
            end else begin
                phase_next = PH_OPCODE;
            end
        end

        // advance to the next string, or back to the opcode wait
        if (str_go && str_last) begin
            if (role_reg == ROLE_AUX_KEY) begin
                role_next  = ROLE_AUX_VAL;
                phase_next = PH_STR_FIRST;
            end else if (role_reg == ROLE_KEY) begin
                role_next  = ROLE_VALUE;
                phase_next = PH_STR_FIRST;
            end else begin
                phase_next = PH_OPCODE;
            end
        end

        // end of file: flag an unfinished structure, then drop all state
        if (in_last_reg) begin
            cut_go = (phase_next != PH_OPCODE && phase_next != PH_AFTER_SELECT &&
                      phase_next != PH_DONE);
            phase_next   = PHASE_INIT;
            hdr_cnt_next = 4'd0;
            remain_next  = 32'd0;
            word_next    = 64'd0;
            idx_next     = 4'd0;
            role_next    = ROLE_AUX_KEY;
            entry_next   = 1'b0;
        end
    end

    // Result item
    always_comb begin
        have = 1'b0;
        item = '{kind: KIND_KEY_BYTE, payload_byte: 8'd0, number: 64'd0,
                 string_done: 1'b0, entry_done: 1'b0, cut_short: 1'b0};
        if (cut_go) begin
            have           = 1'b1;
            item.kind      = KIND_TRUNCATED;
            item.cut_short = 1'b1;
        end else if (eof_go) begin
            have      = 1'b1;
            item.kind = KIND_FILE_END;
        end else if (exp_go) begin
            have        = 1'b1;
            item.kind   = KIND_EXPIRY;
            item.number = exp_ms;
        end else if (str_go && (role_reg == ROLE_KEY || role_reg == ROLE_VALUE)) begin
            have             = 1'b1;
            item.kind        = rdb_kind_t'(((role_reg == ROLE_KEY) ? 4'd0 : 4'd3) +
                                           {2'b00, str_sub});
            item.payload_byte = (str_sub == SUB_BYTE) ? in_data_reg : 8'd0;
            item.number      = (str_sub == SUB_NUMBER) ? int_word : 64'd0;
            item.string_done = str_last;
            item.entry_done  = str_last && (role_reg == ROLE_VALUE);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            phase_reg     <= PHASE_INIT;
            hdr_cnt_reg   <= 4'd0;
            remain_reg    <= 32'd0;
            word_reg      <= 64'd0;
            idx_reg       <= 4'd0;
            role_reg      <= ROLE_AUX_KEY;
            entry_reg     <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end

            if (advance && have) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end

            if (advance) begin
                phase_reg   <= phase_next;
                hdr_cnt_reg <= hdr_cnt_next;
                remain_reg  <= remain_next;
                word_reg    <= word_next;
                idx_reg     <= idx_next;
                role_reg    <= role_next;
                entry_reg   <= entry_next;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data_byte;
            in_last_reg <= s_last_byte;
        end
        if (advance && have) begin
            out_item_reg <= item;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_kind         = out_item_reg.kind;
    assign m_payload_byte = out_item_reg.payload_byte;
    assign m_number       = out_item_reg.number;
    assign m_string_done  = out_item_reg.string_done;
    assign m_entry_done   = out_item_reg.entry_done;
    assign m_cut_short    = out_item_reg.cut_short;

endmodule

[test/tb_rdb_dump_stream_parser.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_rdb_dump_stream_parser
// Feeds dump files one byte word at a time: a directed file that walks an aux
// pair, select, seconds expiry, stray resize byte, integer key, empty value,
// end of file, trailing bytes and a cut-short header. Then random files,
// mostly well formed, some noise and truncation. Each result word is checked
// against the table or an in-bench parser model; random stalls on both sides.
// ----------------------------------------------------------------------------
module tb_rdb_dump_stream_parser;
    import rdb_pkg::*;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       typed;
        rdb_item_t  want;
    } plan_row_t;

    localparam rdb_item_t NO_ITEM = '0;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_data_byte = 8'h00;
    logic        s_last_byte = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [3:0]  m_kind;
    logic [7:0]  m_payload_byte;
    logic [63:0] m_number;
    logic        m_string_done;
    logic        m_entry_done;
    logic        m_cut_short;

    rdb_dump_stream_parser dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_data_byte   (s_data_byte),
        .s_last_byte   (s_last_byte),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_kind        (m_kind),
        .m_payload_byte(m_payload_byte),
        .m_number      (m_number),
        .m_string_done (m_string_done),
        .m_entry_done  (m_entry_done),
        .m_cut_short   (m_cut_short)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Parser model state
    rdb_phase_t  phase;
    logic [3:0]  hdr_seen;
    logic [31:0] remain;
    logic [63:0] acc_word;
    logic [3:0]  acc_pos;
    logic [1:0]  str_role;
    logic        in_entries;
    logic        item_ready;
    rdb_item_t   item_out;

    rdb_item_t   due_items[$];
    rdb_item_t   seen_item;
    rdb_item_t   due_item;
    int          bad_results = 0;

    logic [7:0]  file_bytes[$];
    bit          idle_on = 1'b1;
    bit          send_gaps = 1'b1;
    bit          hold_go = 1'b0;

    function automatic void parser_clear();
        phase      = PHASE_INIT;
        hdr_seen   = 4'd0;
        remain     = 32'd0;
        acc_word   = 64'd0;
        acc_pos    = 4'd0;
        str_role   = ROLE_AUX_KEY;
        in_entries = 1'b0;
    endfunction

    function automatic void set_item(rdb_kind_t k, logic [7:0] pay, logic [63:0] num,
                                      logic sd, logic ed);
        item_ready = 1'b1;
        item_out   = '{k, pay, num, sd, ed, 1'b0};
    endfunction

    function automatic void string_item(logic [1:0] sub, logic [7:0] b, logic [63:0] num,
                                         logic fin);
        rdb_kind_t k;
        logic      is_key;
        is_key = (str_role == ROLE_KEY);
        if (str_role == ROLE_KEY || str_role == ROLE_VALUE) begin
            case (sub)
                SUB_BYTE:   k = is_key ? KIND_KEY_BYTE : KIND_VAL_BYTE;
                SUB_NUMBER: k = is_key ? KIND_KEY_NUMBER : KIND_VAL_NUMBER;
                default:    k = is_key ? KIND_KEY_EMPTY : KIND_VAL_EMPTY;
            endcase
            set_item(k, (sub == SUB_BYTE) ? b : 8'h00, num, fin,
                     fin && str_role == ROLE_VALUE);
        end
        if (!fin)
            return;
        case (str_role)
            ROLE_AUX_KEY: begin
                str_role = ROLE_AUX_VAL;
                phase    = PH_STR_FIRST;
            end
            ROLE_KEY: begin
                str_role = ROLE_VALUE;
                phase    = PH_STR_FIRST;
            end
            default: phase = PH_OPCODE;
        endcase
    endfunction

    function automatic void start_number(logic [31:0] count, rdb_phase_t next);
        acc_word = 64'd0;
        acc_pos  = 4'd0;
        remain   = count;
        phase    = next;
    endfunction

    function automatic void start_body(logic [31:0] len);
        if (len == 32'd0) begin
            string_item(SUB_EMPTY, 8'h00, 64'd0, 1'b1);
        end else begin
            remain = len;
            phase  = PH_STR_BODY;
        end
    endfunction

    function automatic void skip_done();
        if (acc_pos == SKIP_DB_ID) begin
            phase = PH_AFTER_SELECT;
        end else if (acc_pos == SKIP_HASH_SZ) begin
            acc_pos = SKIP_EXPIRE_SZ;
            phase   = PH_SKIPLEN_FIRST;
        end else begin
            phase = PH_OPCODE;
        end
    endfunction

    function automatic void take_opcode(logic [7:0] b);
        if (in_entries && b != OP_AUX && b != OP_SELECT && b != OP_EOF) begin
            if (b == OP_EXPIRY_SEC) begin
                start_number(32'd4, PH_EXPIRY);
            end else if (b == OP_EXPIRY_MS) begin
                start_number(32'd8, PH_EXPIRY);
            end else begin
                str_role = ROLE_KEY;
                phase    = PH_STR_FIRST;
            end
            return;
        end
        in_entries = 1'b0;
        if (b == OP_AUX) begin
            str_role = ROLE_AUX_KEY;
            phase    = PH_STR_FIRST;
        end else if (b == OP_SELECT) begin
            in_entries = 1'b1;
            acc_pos    = SKIP_DB_ID;
            phase      = PH_SKIPLEN_FIRST;
        end else if (b == OP_EOF) begin
            set_item(KIND_FILE_END, 8'h00, 64'd0, 1'b0, 1'b0);
            phase = PH_DONE;
        end
    endfunction

    // Advance the model by one byte word; leaves any result in item_out.
    function automatic void parse_byte(logic [7:0] b, logic fin);
        logic [1:0]  top;
        logic [5:0]  low;
        logic [63:0] ms;
        top        = b[7:6];
        low        = b[5:0];
        item_ready = 1'b0;
        item_out   = NO_ITEM;
        case (phase)
            PH_HEADER: begin
                hdr_seen = hdr_seen + 4'd1;
                if (hdr_seen >= HEADER_BYTES || hdr_seen == 4'd0)
                    phase = PH_OPCODE;
            end
            PH_OPCODE: take_opcode(b);
            PH_AFTER_SELECT: begin
                if (b == OP_RESIZE) begin
                    acc_pos = SKIP_HASH_SZ;
                    phase   = PH_SKIPLEN_FIRST;
                end else begin
                    phase = PH_OPCODE;
                    take_opcode(b);
                end
            end
            PH_SKIPLEN_FIRST: begin
                if (top == LEN_14BIT) begin
                    remain = 32'd1;
                    phase  = PH_SKIPLEN_REST;
                end else if (top == LEN_32BIT) begin
                    remain = 32'd4;
                    phase  = PH_SKIPLEN_REST;
                end else begin
                    skip_done();
                end
            end
            PH_SKIPLEN_REST: begin
                remain = remain - 32'd1;
                if (remain == 32'd0)
                    skip_done();
            end
            PH_STR_FIRST: begin
                if (top == LEN_ENC) begin
                    if (low <= 6'd2)
                        start_number(32'd1 << low, PH_STR_INT);
                    else
                        string_item(SUB_EMPTY, 8'h00, 64'd0, 1'b1);
                end else if (top == LEN_6BIT) begin
                    start_body({26'd0, low});
                end else begin
                    acc_word = (top == LEN_14BIT) ? {58'd0, low} : 64'd0;
                    remain   = (top == LEN_14BIT) ? 32'd1 : 32'd4;
                    phase    = PH_STR_LEN;
                end
            end
            PH_STR_LEN: begin
                acc_word = {32'd0, acc_word[23:0], b};
                remain   = remain - 32'd1;
                if (remain == 32'd0)
                    start_body(acc_word[31:0]);
            end
            PH_STR_INT: begin
                acc_word = acc_word | (64'(b) << (8 * acc_pos[1:0]));
                acc_pos  = acc_pos + 4'd1;
                remain   = remain - 32'd1;
                if (remain == 32'd0)
                    string_item(SUB_NUMBER, 8'h00, acc_word, 1'b1);
            end
            PH_STR_BODY: begin
                remain = remain - 32'd1;
                string_item(SUB_BYTE, b, 64'd0, remain == 32'd0);
            end
            PH_EXPIRY: begin
                acc_word = acc_word | (64'(b) << (8 * acc_pos[2:0]));
                acc_pos  = acc_pos + 4'd1;
                remain   = remain - 32'd1;
                if (remain == 32'd0) begin
                    // four bytes means seconds: scale to ms
                    ms = (acc_pos == 4'd4) ? acc_word * MS_PER_SEC : acc_word;
                    set_item(KIND_EXPIRY, 8'h00, ms, 1'b0, 1'b0);
                    phase = PH_TYPE;
                end
            end
            PH_TYPE: begin
                str_role = ROLE_KEY;
                phase    = PH_STR_FIRST;
            end
            default: ;
        endcase
        if (fin) begin
            if (phase != PH_OPCODE && phase != PH_AFTER_SELECT && phase != PH_DONE) begin
                item_ready         = 1'b1;
                item_out           = NO_ITEM;
                item_out.kind      = KIND_TRUNCATED;
                item_out.cut_short = 1'b1;
            end
            parser_clear();
        end
    endfunction

    // Offer one byte word, hold it until taken, then queue what it causes.
    task automatic push_byte(input logic [7:0] d, input logic fin, input logic typed,
                             input rdb_item_t want);
        int gap;
        @(negedge aclk);
        if (idle_on && send_gaps && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 14);
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid     <= 1'b1;
        s_data_byte <= d;
        s_last_byte <= fin;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        parse_byte(d, fin);
        if (typed)
            due_items.push_back(want);
        else if (item_ready)
            due_items.push_back(item_out);
    endtask

    task automatic add_length(input logic [31:0] len, input bit plain_ok);
        int form;
        form = $urandom_range(0, plain_ok ? 3 : 2);
        if (form == 0 && len < 64) begin
            file_bytes.push_back({LEN_6BIT, len[5:0]});
        end else if (form == 3 && len < 64) begin
            file_bytes.push_back({LEN_ENC, len[5:0]});
        end else if (form == 1 && len < 16384) begin
            file_bytes.push_back({LEN_14BIT, len[13:8]});
            file_bytes.push_back(len[7:0]);
        end else begin
            file_bytes.push_back({LEN_32BIT, 6'($urandom_range(0, 63))});
            file_bytes.push_back(len[31:24]);
            file_bytes.push_back(len[23:16]);
            file_bytes.push_back(len[15:8]);
            file_bytes.push_back(len[7:0]);
        end
    endtask

    task automatic add_string();
        int w;
        int len;
        case ($urandom_range(0, 9))
            0, 1: begin
                w = $urandom_range(0, 2);
                file_bytes.push_back({LEN_ENC, 6'(w)});
                repeat (1 << w) file_bytes.push_back(8'($urandom_range(0, 255)));
            end
            2: file_bytes.push_back({LEN_ENC, 6'($urandom_range(3, 63))});
            default: begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 80)
                                                  : $urandom_range(0, 6);
                add_length(len, 1'b0);
                repeat (len) file_bytes.push_back(8'($urandom_range(0, 255)));
            end
        endcase
    endtask

    task automatic add_skip_length();
        logic [31:0] len;
        len = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 63);
        add_length(len, 1'b1);
    endtask

    task automatic build_file();
        int          cut;
        int          pick;
        logic [7:0]  tb;
        file_bytes.delete();
        repeat (HEADER_BYTES) file_bytes.push_back(8'($urandom_range(0, 255)));
        if ($urandom_range(0, 9) == 0) begin
            // noise file
            repeat ($urandom_range(1, 30)) file_bytes.push_back(8'($urandom_range(0, 255)));
        end else begin
            repeat ($urandom_range(1, 4)) begin
                pick = $urandom_range(0, 5);
                if (pick == 0) begin
                    file_bytes.push_back(OP_AUX);
                    add_string();
                    add_string();
                end else if (pick == 1) begin
                    file_bytes.push_back(8'($urandom_range(0, 8'hF9)));
                end else begin
                    file_bytes.push_back(OP_SELECT);
                    add_skip_length();
                    if ($urandom_range(0, 1) == 0) begin
                        file_bytes.push_back(OP_RESIZE);
                        add_skip_length();
                        add_skip_length();
                    end
                    repeat ($urandom_range(1, 4)) begin
                        case ($urandom_range(0, 3))
                            0: begin
                                file_bytes.push_back(OP_EXPIRY_SEC);
                                repeat (4) file_bytes.push_back(
                                    ($urandom_range(0, 3) == 0) ? 8'hFF
                                                                : 8'($urandom_range(0, 255)));
                                tb = 8'($urandom_range(0, 255));
                            end
                            1: begin
                                file_bytes.push_back(OP_EXPIRY_MS);
                                repeat (8) file_bytes.push_back(8'($urandom_range(0, 255)));
                                tb = 8'($urandom_range(0, 255));
                            end
                            default: begin
                                // a type byte here must not read as an opcode
                                tb = 8'($urandom_range(0, 8'hFA));
                                if (tb == OP_AUX)
                                    tb = OP_RESIZE;
                            end
                        endcase
                        file_bytes.push_back(tb);
                        add_string();
                        add_string();
                    end
                end
            end
            if ($urandom_range(0, 9) != 0)
                file_bytes.push_back(OP_EOF);
            repeat ($urandom_range(0, 2)) file_bytes.push_back(8'($urandom_range(0, 255)));
        end
        if ($urandom_range(0, 4) == 0) begin
            cut = $urandom_range(0, file_bytes.size() - 1);
            while (file_bytes.size() > cut + 1) void'(file_bytes.pop_back());
        end
    endtask

    // Result checker
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            seen_item = {m_kind, m_payload_byte, m_number, m_string_done, m_entry_done,
                         m_cut_short};
            if (due_items.size() == 0) begin
                bad_results++;
                if (bad_results <= 10)
                    $display("unexpected word: kind %0d byte %02h number %016h sd %b ed %b cut %b",
                             seen_item.kind, seen_item.payload_byte, seen_item.number,
                             seen_item.string_done, seen_item.entry_done, seen_item.cut_short);
            end else begin
                due_item = due_items.pop_front();
                if (seen_item !== due_item) begin
                    bad_results++;
                    if (bad_results <= 10) begin
                        $display("mismatch: expected kind %0d byte %02h number %016h sd %b ed %b cut %b",
                                 due_item.kind, due_item.payload_byte, due_item.number,
                                 due_item.string_done, due_item.entry_done, due_item.cut_short);
                        $display("          actual   kind %0d byte %02h number %016h sd %b ed %b cut %b",
                                 seen_item.kind, seen_item.payload_byte, seen_item.number,
                                 seen_item.string_done, seen_item.entry_done, seen_item.cut_short);
                    end
                end
            end
        end
    end

    // Result side: random stalls, plus one long hold-off while input keeps coming
    initial begin
        int  gap;
        int  hold_cycles;
        bit  hold_done;
        hold_done = 1'b0;
        wait (aresetn);
        forever begin
            @(negedge aclk);
            if (hold_go && !hold_done) begin
                hold_done = 1'b1;
                m_ready <= 1'b0;
                for (hold_cycles = 0; hold_cycles < 400; hold_cycles++) @(negedge aclk);
                m_ready <= 1'b1;
            end else if (idle_on && $urandom_range(0, 7) == 0) begin
                gap = $urandom_range(1, 14);
                m_ready <= 1'b0;
                repeat (gap) @(negedge aclk);
                m_ready <= 1'b1;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    initial begin
        #2_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        plan_row_t directed_rows [0:25];
        int        row;
        int        body;
        int        i;
        bit        paused;
        directed_rows = '{
            // header, extremes of the byte
            '{8'h00, 1'b0, 1'b0, NO_ITEM},
            '{8'hFF, 1'b0, 1'b0, NO_ITEM},
            '{8'h52, 1'b0, 1'b0, NO_ITEM},
            '{8'h44, 1'b0, 1'b0, NO_ITEM},
            '{8'h42, 1'b0, 1'b0, NO_ITEM},
            '{8'h30, 1'b0, 1'b0, NO_ITEM},
            '{8'h30, 1'b0, 1'b0, NO_ITEM},
            '{8'h31, 1'b0, 1'b0, NO_ITEM},
            '{8'h31, 1'b0, 1'b0, NO_ITEM},
            // aux pair of empty strings: silent
            '{OP_AUX, 1'b0, 1'b0, NO_ITEM},
            '{8'hC3, 1'b0, 1'b0, NO_ITEM},
            '{8'hC3, 1'b0, 1'b0, NO_ITEM},
            '{OP_SELECT, 1'b0, 1'b0, NO_ITEM},
            '{8'h00, 1'b0, 1'b0, NO_ITEM},
            // largest seconds expiry
            '{OP_EXPIRY_SEC, 1'b0, 1'b0, NO_ITEM},
            '{8'hFF, 1'b0, 1'b0, NO_ITEM},
            '{8'hFF, 1'b0, 1'b0, NO_ITEM},
            '{8'hFF, 1'b0, 1'b0, NO_ITEM},
            '{8'hFF, 1'b0, 1'b1, '{KIND_EXPIRY, 8'h00, 64'd4294967295000, 1'b0, 1'b0, 1'b0}},
            // stray resize byte taken as the type
            '{OP_RESIZE, 1'b0, 1'b0, NO_ITEM},
            '{8'hC0, 1'b0, 1'b0, NO_ITEM},
            '{8'hFF, 1'b0, 1'b1, '{KIND_KEY_NUMBER, 8'h00, 64'd255, 1'b1, 1'b0, 1'b0}},
            '{8'hC3, 1'b0, 1'b1, '{KIND_VAL_EMPTY, 8'h00, 64'd0, 1'b1, 1'b1, 1'b0}},
            '{OP_EOF, 1'b0, 1'b1, '{KIND_FILE_END, 8'h00, 64'd0, 1'b0, 1'b0, 1'b0}},
            // trailing byte after end of file, then a file cut in its header
            '{8'h5A, 1'b1, 1'b0, NO_ITEM},
            '{8'h00, 1'b1, 1'b1, '{KIND_TRUNCATED, 8'h00, 64'd0, 1'b0, 1'b0, 1'b1}}
        };
        parser_clear();
        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;

        for (row = 0; row < 26; row++)
            push_byte(directed_rows[row].data, directed_rows[row].last,
                      directed_rows[row].typed, directed_rows[row].want);

        body   = 0;
        paused = 1'b0;
        while (body < 700) begin
            build_file();
            if (file_bytes.size() > HEADER_BYTES)
                body += file_bytes.size() - HEADER_BYTES;
            send_gaps = ($urandom_range(0, 3) != 0);
            if (body >= 150)
                hold_go = 1'b1;
            if (body >= 600)
                idle_on = 1'b0;
            for (i = 0; i < file_bytes.size(); i++)
                push_byte(file_bytes[i], i == file_bytes.size() - 1, 1'b0, NO_ITEM);
            if (!paused && body >= 350) begin
                // drain everything before going on
                paused = 1'b1;
                @(negedge aclk);
                s_valid <= 1'b0;
                wait (due_items.size() == 0);
            end
        end

        @(negedge aclk);
        s_valid <= 1'b0;
        wait (due_items.size() == 0);
        repeat (16) @(posedge aclk);
        if (bad_results == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
